[hw/rtl/ssq_pkg.sv]
package ssq_pkg;

  // Operation carried with every input beat.
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Result status code.
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY_ERROR  = 2'd1,
    ST_FULL_DROPPED = 2'd2
  } status_t;

  // Controller states: whether the result register holds an unread beat.
  typedef enum logic {
    CS_IDLE   = 1'b0,
    CS_RESULT = 1'b1
  } ctrl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic  exec;
    mode_t mode;
  } ctrl_cmd_t;

endpackage

[hw/rtl/ssq_ctrl.sv]
module ssq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_mode,
  input  logic              out_tready,
  output logic              in_tready,
  output logic              out_tvalid,
  output ssq_pkg::ctrl_cmd_t cmd
);
  import ssq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new beat is taken whenever the result register is free or being emptied.
  always_comb begin
    state_nxt  = state_r;
    out_tvalid = 1'b0;
    in_tready  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
      end
      CS_RESULT: begin
        out_tvalid = 1'b1;
        in_tready  = out_tready;
      end
    endcase
    cmd.exec = in_tvalid && in_tready;
    cmd.mode = mode_t'(in_mode);
    if (cmd.exec) begin
      state_nxt = CS_RESULT;
    end else if (out_tready) begin
      state_nxt = CS_IDLE;
    end
  end

endmodule

[hw/rtl/ssq_datapath.sv]
module ssq_datapath #(
  parameter int CAPACITY       = 16,
  parameter int VALUE_WIDTH    = 8,
  parameter int PRIORITY_WIDTH = 8,
  parameter int CNT_W          = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssq_pkg::ctrl_cmd_t               cmd,
  input  logic        [VALUE_WIDTH-1:0]    data_value,
  input  logic signed [PRIORITY_WIDTH-1:0] priority_req,
  output logic        [VALUE_WIDTH-1:0]    head_value,
  output logic                             head_valid,
  output logic                             is_empty,
  output logic        [CNT_W-1:0]          entry_count,
  output ssq_pkg::status_t                 status
);
  import ssq_pkg::*;

  logic        [VALUE_WIDTH-1:0]    slot_val_r [CAPACITY];
  logic signed [PRIORITY_WIDTH-1:0] slot_pri_r [CAPACITY];
  logic        [VALUE_WIDTH-1:0]    slot_val_nxt [CAPACITY];
  logic signed [PRIORITY_WIDTH-1:0] slot_pri_nxt [CAPACITY];
  logic        [CNT_W-1:0]          count_r;
  logic        [CNT_W-1:0]          count_nxt;
  logic        [CAPACITY-1:0]       stay;

  logic        [VALUE_WIDTH-1:0]    head_value_r;
  logic                             head_valid_r;
  status_t                          status_r;
  logic        [VALUE_WIDTH-1:0]    head_value_nxt;
  logic                             head_valid_nxt;
  status_t                          status_nxt;

  logic is_full;
  logic is_none;

  assign is_full = (count_r == CNT_W'(CAPACITY));
  assign is_none = (count_r == '0);

  // Per-slot cells: an occupied slot whose priority is at least the new one
  // keeps its entry on a push; all slots behind it move down by one.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign stay[i] = (CNT_W'(i) < count_r) && (slot_pri_r[i] >= priority_req);

    always_comb begin
      slot_val_nxt[i] = slot_val_r[i];
      slot_pri_nxt[i] = slot_pri_r[i];
      if (cmd.exec) begin
        if (cmd.mode == MODE_PUSH && !is_full) begin
          if (!stay[i]) begin
            if (i == 0) begin
              slot_val_nxt[i] = data_value;
              slot_pri_nxt[i] = priority_req;
            end else if (stay[(i == 0) ? 0 : i - 1]) begin
              slot_val_nxt[i] = data_value;
              slot_pri_nxt[i] = priority_req;
            end else begin
              slot_val_nxt[i] = slot_val_r[(i == 0) ? 0 : i - 1];
              slot_pri_nxt[i] = slot_pri_r[(i == 0) ? 0 : i - 1];
            end
          end
        end else if (cmd.mode == MODE_POP && !is_none && i < CAPACITY - 1) begin
          slot_val_nxt[i] = slot_val_r[(i < CAPACITY - 1) ? i + 1 : i];
          slot_pri_nxt[i] = slot_pri_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    // Slot storage carries no reset; only occupied slots are ever read.
    always_ff @(posedge clk) begin
      slot_val_r[i] <= slot_val_nxt[i];
      slot_pri_r[i] <= slot_pri_nxt[i];
    end
  end

  // Entry count and result fields for the accepted beat.
  always_comb begin
    count_nxt      = count_r;
    head_value_nxt = '0;
    head_valid_nxt = 1'b0;
    status_nxt     = ST_OK;
    unique case (cmd.mode)
      MODE_PUSH: begin
        if (is_full) begin
          status_nxt = ST_FULL_DROPPED;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (is_none) begin
          status_nxt = ST_EMPTY_ERROR;
        end else begin
          head_value_nxt = slot_val_r[0];
          head_valid_nxt = 1'b1;
          if (cmd.mode == MODE_POP) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
    endcase
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Result register, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      head_value_r <= head_value_nxt;
      head_valid_r <= head_valid_nxt;
      status_r     <= status_nxt;
    end
  end

  assign head_value  = head_value_r;
  assign head_valid  = head_valid_r;
  assign status      = status_r;
  assign entry_count = count_r;
  assign is_empty    = is_none;

endmodule

[hw/rtl/stable_sorted_priority_queue_unit.sv]
// Bounded priority queue of CAPACITY value/priority pairs, kept sorted with the
// highest signed priority at the head; equal priorities leave in arrival order.
// Each input beat carries an operation in in_tuser (0 push, 1 pop, 2 peek,
// 3 clear) and produces exactly one result beat with the head value (pop and
// peek), a valid flag, an empty flag, the entry count after the operation and
// a status (0 ok, 1 pop or peek on an empty queue, 2 push dropped when full).
// Each storage slot is a cell with its own priority compare and shift mux, so an
// insert or a removal updates all slots at the edge that accepts the beat, and
// the result is loaded into an output register at that same edge and offered
// from the next cycle. A new beat is accepted every cycle as long as the result
// register is empty or being read in that cycle. No clearing pass is needed
// after reset.
module stable_sorted_priority_queue_unit #(
  parameter int CAPACITY       = 16,
  parameter int VALUE_WIDTH    = 8,
  parameter int PRIORITY_WIDTH = 8,
  localparam int CNT_W         = $clog2(CAPACITY + 1),
  localparam int IN_W          = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
  localparam int OUT_W         = ((VALUE_WIDTH + CNT_W + 4 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // data_value, priority_req (signed), zero pad
  input  logic [1:0]       in_tuser,   // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // head_value, head_valid, is_empty,
                                       // entry_count, status, zero pad
);
  import ssq_pkg::*;

  ctrl_cmd_t                        cmd;
  logic        [VALUE_WIDTH-1:0]    head_value;
  logic                             head_valid;
  logic                             is_empty;
  logic        [CNT_W-1:0]          entry_count;
  status_t                          status;
  logic signed [PRIORITY_WIDTH-1:0] priority_req;

  assign priority_req = $signed(in_tdata[VALUE_WIDTH +: PRIORITY_WIDTH]);

  // Handshake control and output register occupancy.
  ssq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // Sorted slot cells, count and result register.
  ssq_datapath #(
    .CAPACITY       (CAPACITY),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .CNT_W          (CNT_W)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .data_value   (in_tdata[VALUE_WIDTH-1:0]),
    .priority_req (priority_req),
    .head_value   (head_value),
    .head_valid   (head_valid),
    .is_empty     (is_empty),
    .entry_count  (entry_count),
    .status       (status)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = OUT_W'({status, entry_count, is_empty, head_valid, head_value});

endmodule
